FILE: rtl/hvcs_pkg.sv
// Package for the hypervector store with cosine similarity.
// Request and result payload types, request and status codes, controller links.
// No dependencies.
`default_nettype none

package hvcs_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_LEN_DEF   = 1024;

    // Request codes
    localparam logic [1:0] REQ_STORE = 2'd0;
    localparam logic [1:0] REQ_EMPTY = 2'd1;
    localparam logic [1:0] REQ_CMP   = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_DEGEN   = 2'd2;

    // Sine polynomial coefficients (Q.16) and magnitude floor (Q2.30)
    localparam logic [31:0] SIN_A   = 32'd102944;
    localparam logic [31:0] SIN_B   = 32'd42047;
    localparam logic [31:0] SIN_C   = 32'd4640;
    localparam logic [31:0] EPS_Q30 = 32'd107374;

    // Quotient bits produced by the divider
    localparam int DIV_QB = 17;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         layer_a;
        logic [3:0]         layer_b;
        logic [9:0]         element_index;
        logic signed [15:0] weight;
        logic               last_element;
    } in_t;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic lookup;
        logic walk;
        logic check;
        logic root_step;
        logic mul;
        logic div_init;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic lookup_err;
        logic walk_done;
        logic tiny;
        logic iter_done;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/hvcs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hvcs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr0,
    output logic      [WIDTH-1:0]  rdata0,
    input  wire logic [ADDR_W-1:0] raddr1,
    output logic      [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

`default_nettype wire

FILE: rtl/hvcs_ctrl.sv
// Controller state machine: request handshake, sequencing, result valid.
// Depends on hvcs_pkg.
`default_nettype none

module hvcs_ctrl
    import hvcs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_req,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SIN1   = 14'b00000000000010,
        S_SIN2   = 14'b00000000000100,
        S_SIN3   = 14'b00000000001000,
        S_SIN4   = 14'b00000000010000,
        S_WRITE  = 14'b00000000100000,
        S_LOOKUP = 14'b00000001000000,
        S_WALK   = 14'b00000010000000,
        S_CHECK  = 14'b00000100000000,
        S_ROOT   = 14'b00001000000000,
        S_MUL    = 14'b00010000000000,
        S_DIVI   = 14'b00100000000000,
        S_DIV    = 14'b01000000000000,
        S_RESULT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_req)
                        REQ_STORE: state_next = S_SIN1;
                        REQ_EMPTY: state_next = S_WRITE;
                        REQ_CMP:   state_next = S_LOOKUP;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SIN1:  state_next = S_SIN2;
            S_SIN2:  state_next = S_SIN3;
            S_SIN3:  state_next = S_SIN4;
            S_SIN4:  state_next = S_WRITE;
            S_WRITE: begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = stat.lookup_err ? S_RESULT : S_WALK;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (stat.walk_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.tiny ? S_RESULT : S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.iter_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.iter_done) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hvcs_dp.sv
// Datapath: sine mapping, slot table, vector memory walk, square roots, divider.
// Depends on hvcs_pkg and hvcs_ram.
`default_nettype none

module hvcs_dp
    import hvcs_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire cmd_t cmd,
    output stat_t     stat,
    output out_t      m_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int DEPTH  = NUM_SLOTS * MAX_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAG_W  = 31 + $clog2(MAX_LEN);
    localparam int DOT_W  = MAG_W + 1;
    localparam int RW     = (MAG_W + 1) / 2;
    localparam int SQ_W   = 2 * RW;
    localparam int DW     = 2 * RW;
    localparam int ITER_W = $clog2(((RW > DIV_QB) ? RW : DIV_QB) + 1);

    // ---- captured request ----
    logic [1:0]        req_reg;
    logic [SLOT_W-1:0] slot_a_reg, slot_b_reg;
    logic              a_ok_reg, b_ok_reg, idx_ok_reg, last_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [15:0]       z_reg;
    logic [1:0]        quad_reg;

    logic [11:0] r0, r1;
    assign r0 = {1'b0, s_data.weight[10:0]};
    assign r1 = s_data.weight[11] ? (12'd2048 - r0) : r0;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= s_data.req_type;
            slot_a_reg <= SLOT_W'(s_data.layer_a);
            slot_b_reg <= SLOT_W'(s_data.layer_b);
            a_ok_reg   <= (32'(s_data.layer_a) < NUM_SLOTS);
            b_ok_reg   <= (32'(s_data.layer_b) < NUM_SLOTS);
            idx_ok_reg <= (32'(s_data.element_index) < MAX_LEN);
            idx_reg    <= LEN_W'(s_data.element_index);
            last_reg   <= s_data.last_element;
            z_reg      <= {r1, 4'b0000};
            quad_reg   <= s_data.weight[12:11];
        end
    end

    // ---- sine polynomial, free-running chain of one multiply per stage ----
    logic [15:0] z2_reg, t1_reg;
    logic [16:0] t2_reg;
    logic [15:0] elem_reg;
    logic [31:0] p_z2, p_t1, p_t2, p_y;
    logic [17:0] y_rnd;
    logic [14:0] y_sat;

    assign p_z2  = {16'd0, z_reg} * {16'd0, z_reg};
    assign p_t1  = SIN_C * {16'd0, z2_reg};
    assign p_t2  = {16'd0, t1_reg} * {16'd0, z2_reg};
    assign p_y   = {15'd0, t2_reg} * {16'd0, z_reg};
    assign y_rnd = (18'(p_y >> 15) + 18'd1) >> 1;
    assign y_sat = (y_rnd > 18'd32767) ? 15'h7fff : y_rnd[14:0];

    always_ff @(posedge aclk) begin
        z2_reg   <= 16'(p_z2 >> 15);
        t1_reg   <= 16'(SIN_B - (p_t1 >> 15));
        t2_reg   <= 17'(SIN_A - (p_t2 >> 15));
        elem_reg <= quad_reg[1] ? (16'd0 - {1'b0, y_sat}) : {1'b0, y_sat};
    end

    // ---- slot table: valid flags in flops, lengths in RAM ----
    logic [NUM_SLOTS-1:0] valid_reg;
    logic                 len_we;
    logic [LEN_W-1:0]     len_wdata, len_a, len_b;
    logic                 vec_we;
    logic [AW-1:0]        vec_waddr;
    logic                 store_ok;

    assign store_ok  = (req_reg == REQ_STORE) && a_ok_reg && idx_ok_reg;
    assign vec_we    = cmd.commit && store_ok;
    assign vec_waddr = AW'(slot_a_reg) * AW'(MAX_LEN) + AW'(idx_reg);
    assign len_we    = cmd.commit && ((store_ok && last_reg)
                       || ((req_reg == REQ_EMPTY) && a_ok_reg));
    assign len_wdata = (req_reg == REQ_EMPTY) ? '0 : idx_reg + LEN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (len_we) begin
            valid_reg[slot_a_reg] <= 1'b1;
        end
    end

    hvcs_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (slot_a_reg),
        .wdata (len_wdata),
        .raddr0(SLOT_W'(s_data.layer_a)),
        .rdata0(len_a),
        .raddr1(SLOT_W'(s_data.layer_b)),
        .rdata1(len_b)
    );

    // ---- lookup ----
    logic [LEN_W-1:0] len_min;
    logic [1:0]       look_err;
    logic [1:0]       err_reg;
    logic [LEN_W-1:0] len_reg, cnt_reg;
    logic [AW-1:0]    base_a_reg, base_b_reg;

    assign len_min = (len_a < len_b) ? len_a : len_b;

    always_comb begin
        if (!(a_ok_reg && b_ok_reg && valid_reg[slot_a_reg] && valid_reg[slot_b_reg])) begin
            look_err = STAT_MISSING;
        end else if (len_min == '0) begin
            look_err = STAT_DEGEN;
        end else begin
            look_err = STAT_OK;
        end
    end

    assign stat.lookup_err = (look_err != STAT_OK);

    // ---- vector walk: address, read, multiply, accumulate ----
    logic                    issue;
    logic                    rd_v_reg, pr_v_reg;
    logic signed [15:0]      va, vb;
    logic signed [31:0]      pd_reg;
    logic [30:0]             pa_reg, pb_reg;
    logic signed [31:0]      pd_w, pa_w, pb_w;
    logic signed [DOT_W-1:0] dot_reg;
    logic [MAG_W-1:0]        m1_reg, m2_reg;

    assign issue = cmd.walk && (cnt_reg != len_reg);
    assign pd_w  = va * vb;
    assign pa_w  = va * va;
    assign pb_w  = vb * vb;

    hvcs_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (elem_reg),
        .raddr0(base_a_reg + AW'(cnt_reg)),
        .rdata0(va),
        .raddr1(base_b_reg + AW'(cnt_reg)),
        .rdata1(vb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= issue;
            pr_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        pd_reg <= pd_w;
        pa_reg <= pa_w[30:0];
        pb_reg <= pb_w[30:0];
        if (cmd.lookup) begin
            err_reg    <= look_err;
            len_reg    <= len_min;
            cnt_reg    <= '0;
            base_a_reg <= AW'(slot_a_reg) * AW'(MAX_LEN);
            base_b_reg <= AW'(slot_b_reg) * AW'(MAX_LEN);
            dot_reg    <= '0;
            m1_reg     <= '0;
            m2_reg     <= '0;
        end else begin
            if (issue) begin
                cnt_reg <= cnt_reg + LEN_W'(1);
            end
            if (pr_v_reg) begin
                dot_reg <= dot_reg + DOT_W'(pd_reg);
                m1_reg  <= m1_reg + MAG_W'(pa_reg);
                m2_reg  <= m2_reg + MAG_W'(pb_reg);
            end
        end
        if (cmd.check && stat.tiny) begin
            err_reg <= STAT_DEGEN;
        end
    end

    assign stat.walk_done = (cnt_reg == len_reg) && !rd_v_reg && !pr_v_reg;

    // ---- magnitude floor and square roots (one result bit per cycle each) ----
    logic [MAG_W-1:0] eps_w, mc1, mc2;
    logic [SQ_W-1:0]  op_reg   [2];
    logic [RW+1:0]    rem_reg  [2];
    logic [RW-1:0]    root_reg [2];
    logic [RW+1:0]    rem_sh   [2];
    logic [RW+1:0]    trial    [2];
    logic [ITER_W-1:0] iter_reg;

    assign eps_w     = MAG_W'(EPS_Q30);
    assign stat.tiny = (m1_reg <= eps_w) && (m2_reg <= eps_w);
    assign mc1       = (m1_reg < eps_w) ? eps_w : m1_reg;
    assign mc2       = (m2_reg < eps_w) ? eps_w : m2_reg;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            rem_sh[i] = {rem_reg[i][RW-1:0], op_reg[i][SQ_W-1 -: 2]};
            trial[i]  = {root_reg[i], 2'b01};
        end
    end

    // ---- divider: restoring, one quotient bit per cycle ----
    logic [DW-1:0]      d_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [DW:0]        drem_reg, drem_sh;
    logic [DIV_QB-1:0]  nlo_reg, quo_reg;
    logic signed [DOT_W-1:0] dot_abs;

    assign dot_abs = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;
    assign drem_sh = {drem_reg[DW-1:0], nlo_reg[DIV_QB-1]};

    assign stat.iter_done = (iter_reg == ITER_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            op_reg[0]   <= SQ_W'(mc1);
            op_reg[1]   <= SQ_W'(mc2);
            rem_reg[0]  <= '0;
            rem_reg[1]  <= '0;
            root_reg[0] <= '0;
            root_reg[1] <= '0;
            iter_reg    <= ITER_W'(RW);
            neg_reg     <= dot_reg[DOT_W-1];
            mag_reg     <= MAG_W'(dot_abs);
        end
        if (cmd.root_step) begin
            for (int i = 0; i < 2; i++) begin
                op_reg[i] <= op_reg[i] << 2;
                if (rem_sh[i] >= trial[i]) begin
                    rem_reg[i]  <= rem_sh[i] - trial[i];
                    root_reg[i] <= {root_reg[i][RW-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= rem_sh[i];
                    root_reg[i] <= {root_reg[i][RW-2:0], 1'b0};
                end
            end
            iter_reg <= iter_reg - ITER_W'(1);
        end
        if (cmd.mul) begin
            d_reg <= DW'(root_reg[0]) * DW'(root_reg[1]);
        end
        if (cmd.div_init) begin
            drem_reg <= (DW + 1)'(mag_reg >> 2);
            nlo_reg  <= {mag_reg[1:0], 15'd0};
            quo_reg  <= '0;
            iter_reg <= ITER_W'(DIV_QB);
        end
        if (cmd.div_step) begin
            nlo_reg <= nlo_reg << 1;
            if (drem_sh >= {1'b0, d_reg}) begin
                drem_reg <= drem_sh - {1'b0, d_reg};
                quo_reg  <= {quo_reg[DIV_QB-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh;
                quo_reg  <= {quo_reg[DIV_QB-2:0], 1'b0};
            end
            iter_reg <= iter_reg - ITER_W'(1);
        end
    end

    // ---- result register ----
    logic [DIV_QB-1:0] q_sat;
    logic [15:0]       sim;

    always_comb begin
        if (neg_reg) begin
            q_sat = (quo_reg > DIV_QB'(32768)) ? DIV_QB'(32768) : quo_reg;
            sim   = 16'(DIV_QB'(0) - q_sat);
        end else begin
            q_sat = (quo_reg > DIV_QB'(32767)) ? DIV_QB'(32767) : quo_reg;
            sim   = q_sat[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data.status     <= err_reg;
            m_data.similarity <= (err_reg == STAT_OK) ? sim : 16'sd0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hypervector_store_cosine_similarity.sv
// Top level of the hypervector store with cosine similarity.
// Joins hvcs_ctrl and hvcs_dp; depends on hvcs_pkg.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | s_data (in_t)
//   m_      | out | m_valid / m_ready  | m_data (out_t), one per compare
//
// One request at a time. Element store: 4-stage sine chain, then memory write.
// Store-empty: the slot-table write alone. Compare: the element walk over
// the vector memory, then RW = (32 + clog2(MAX_LEN)) / 2 bit-serial
// square-root steps, the multiply of the two roots and the
// 17-step divider. Reset clears slot validity, not the vector memory.
// A result waiting on m_ready holds in the output register; the next request
// is taken meanwhile and stalls only if it finishes with the result still held.
`default_nettype none

module hypervector_store_cosine_similarity
    import hvcs_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_LEN   = MAX_LEN_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    cmd_t  cmd;
    stat_t stat;

    hvcs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_req  (s_data.req_type),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    hvcs_dp #(
        .NUM_SLOTS(NUM_SLOTS),
        .MAX_LEN  (MAX_LEN)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .m_data (m_data)
    );

endmodule

`default_nettype wire

FILE: rtl/hvcs_chk.sv
// Port-level checker for the hypervector store, bound to the top level.
// Depends on hvcs_pkg.
`default_nettype none

module hvcs_chk
    import hvcs_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // error status always carries a zero similarity
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.similarity == 16'sd0)
        else $error("nonzero similarity with error status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code");

    // every real request is accepted into a busy state, which drops s_ready
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type != REQ_RSVD |=> !s_ready)
        else $error("request taken while previous one still in progress");

endmodule

bind hypervector_store_cosine_similarity hvcs_chk u_chk (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
